FILE: design/tgaunp_pkg.sv
// types, codes and helpers shared by the targa pixel unpacker files
`default_nettype none
package tgaunp_pkg;

  typedef enum logic {
    OP_DECODE        = 1'b0,
    OP_PALETTE_WRITE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    REG_PALETTE_MODE        = 3'd0,
    REG_SOURCE_BYTES        = 3'd1,
    REG_PALETTE_ENTRY_BYTES = 3'd2,
    REG_PALETTE_FIRST       = 3'd3,
    REG_PALETTE_COUNT       = 3'd4
  } cfg_reg_e;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
  localparam int unsigned CFG_DATA_W  = 9;

  typedef struct packed {
    op_e         operation;
    logic [31:0] raw_pixel;
    logic [7:0]  entry_index;
    logic [31:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] channel_blue;
    logic [7:0] channel_green;
    logic [7:0] channel_red;
    logic [7:0] channel_alpha;
    logic       decode_ok;
  } out_item_t;

  typedef struct packed {
    cfg_reg_e              index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_item_t;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    widen5 = {v, v[4:2]};
  endfunction

endpackage
`default_nettype wire

FILE: design/tgaunp_if.sv
// handshake channels for pixel items, result items and register writes
`default_nettype none
interface tgaunp_in_if;
  logic                valid;
  logic                ready;
  tgaunp_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tgaunp_out_if;
  logic                 valid;
  logic                 ready;
  tgaunp_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tgaunp_cfg_if;
  logic                 valid;
  logic                 ready;
  tgaunp_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/tgaunp_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module tgaunp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: design/targa_pixel_unpacker_core.sv
// Targa pixel unpacker top level: raw pixel bytes in, blue/green/red/alpha out.
// One item is taken per clock while the output side is not stalled. A decode
// transfer is registered at the palette ram's read and the second stage beside
// it, then in the output register; every decode passes through that ram read
// whether or not palette mode is on. A palette write lands in the table on its
// transfer edge and gives no result, so a decode in the very next cycle already
// sees it. Registers may be written only while the block is empty.
`default_nettype none
module targa_pixel_unpacker_core #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  tgaunp_in_if.sink      in_i,
  tgaunp_out_if.source   out_o,
  tgaunp_cfg_if.sink     cfg_i
);

  localparam int unsigned AW = $clog2(PALETTE_DEPTH);

  // configuration registers
  logic       palette_mode_q;
  logic [2:0] source_bytes_q;
  logic [2:0] entry_bytes_q;
  logic [8:0] palette_first_q;
  logic [8:0] palette_count_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_mode_q  <= 1'b0;
      source_bytes_q  <= 3'd4;
      entry_bytes_q   <= 3'd4;
      palette_first_q <= 9'd0;
      palette_count_q <= 9'd256;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        tgaunp_pkg::REG_PALETTE_MODE:        palette_mode_q  <= cfg_i.data.value[0];
        tgaunp_pkg::REG_SOURCE_BYTES:        source_bytes_q  <= cfg_i.data.value[2:0];
        tgaunp_pkg::REG_PALETTE_ENTRY_BYTES: entry_bytes_q   <= cfg_i.data.value[2:0];
        tgaunp_pkg::REG_PALETTE_FIRST:       palette_first_q <= cfg_i.data.value[8:0];
        tgaunp_pkg::REG_PALETTE_COUNT:       palette_count_q <= cfg_i.data.value[8:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic s1_valid_q;
  logic out_valid_q;
  logic out_free;
  logic in_xfer;
  logic is_decode;

  assign out_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_xfer   = in_i.valid && in_i.ready;
  assign is_decode = (in_i.data.operation == tgaunp_pkg::OP_DECODE);

  // front stage: direct decode and palette checks
  logic [31:0] raw;
  logic [7:0]  b0;
  logic [8:0]  rel;
  logic        in_window;
  logic        pal_ok;
  logic        dir_ok;
  logic [7:0]  dir_ch [4];

  assign raw = in_i.data.raw_pixel;
  assign b0  = raw[7:0];
  assign rel = {1'b0, b0} - palette_first_q;

  always_comb begin
    in_window = ({1'b0, b0} >= palette_first_q) && (rel < palette_count_q)
                && ({1'b0, b0} < 9'(PALETTE_DEPTH));
    pal_ok    = (source_bytes_q == 3'd1)
                && ((entry_bytes_q == 3'd3) || (entry_bytes_q == 3'd4))
                && in_window;
  end

  always_comb begin
    dir_ok    = 1'b1;
    dir_ch[0] = b0;
    dir_ch[1] = raw[15:8];
    dir_ch[2] = raw[23:16];
    dir_ch[3] = raw[31:24];
    case (source_bytes_q)
      3'd4: ;
      3'd3: dir_ch[3] = tgaunp_pkg::ALPHA_OPAQUE;
      3'd2: begin
        dir_ch[0] = tgaunp_pkg::widen5(raw[4:0]);
        dir_ch[1] = tgaunp_pkg::widen5(raw[9:5]);
        dir_ch[2] = tgaunp_pkg::widen5(raw[14:10]);
        dir_ch[3] = raw[15] ? tgaunp_pkg::ALPHA_OPAQUE : tgaunp_pkg::ALPHA_CLEAR;
      end
      3'd1: begin
        dir_ch[1] = b0;
        dir_ch[2] = b0;
        dir_ch[3] = tgaunp_pkg::ALPHA_OPAQUE;
      end
      default: dir_ok = 1'b0;
    endcase
  end

  // palette table
  logic [31:0] entry;

  tgaunp_ram #(
    .WIDTH (32),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (in_xfer && !is_decode
              && ({1'b0, in_i.data.entry_index} < 9'(PALETTE_DEPTH))),
    .waddr_i (in_i.data.entry_index[AW-1:0]),
    .wdata_i (in_i.data.entry_value),
    .re_i    (in_xfer && is_decode),
    .raddr_i (b0[AW-1:0]),
    .rdata_o (entry)
  );

  // second stage, aligned with the ram read data
  logic       s1_pal_q;
  logic       s1_ok_q;
  logic       s1_e4_q;
  logic [7:0] s1_ch_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_xfer && is_decode;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && is_decode) begin
      s1_pal_q <= palette_mode_q;
      s1_ok_q  <= palette_mode_q ? pal_ok : dir_ok;
      s1_e4_q  <= (entry_bytes_q == 3'd4);
      s1_ch_q  <= dir_ch;
    end
  end

  tgaunp_pkg::out_item_t res;

  always_comb begin
    res = '0;
    if (s1_ok_q) begin
      res.decode_ok = 1'b1;
      if (s1_pal_q) begin
        res.channel_blue  = entry[7:0];
        res.channel_green = entry[15:8];
        res.channel_red   = entry[23:16];
        res.channel_alpha = s1_e4_q ? entry[31:24] : tgaunp_pkg::ALPHA_OPAQUE;
      end else begin
        res.channel_blue  = s1_ch_q[0];
        res.channel_green = s1_ch_q[1];
        res.channel_red   = s1_ch_q[2];
        res.channel_alpha = s1_ch_q[3];
      end
    end
  end

  // output register
  tgaunp_pkg::out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q) begin
      out_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule
`default_nettype wire

FILE: dv/tgaunp_checker.sv
// checker for the targa pixel unpacker: watches all channels, predicts and compares results
module tgaunp_checker
  import tgaunp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tgaunp_in_if      pix_i,
  tgaunp_out_if     res_i,
  tgaunp_cfg_if     reg_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_count_o
);

  out_item_t   expected_pixels[$];
  logic [31:0] palette_shadow [256];
  logic        mode_q;
  logic [2:0]  src_bytes_q;
  logic [2:0]  entry_bytes_q;
  logic [8:0]  first_q;
  logic [8:0]  count_q;
  int unsigned faults;
  out_item_t   want;

  function automatic logic [7:0] expand5(input logic [4:0] f);
    return {f, f[4:2]};
  endfunction

  function automatic out_item_t unpack_pixel(input logic [31:0] raw);
    out_item_t   r;
    logic [31:0] word;
    int unsigned idx;
    r = '0;
    idx = 32'(raw[7:0]);
    if (mode_q) begin
      if (src_bytes_q == 3'd1 && (entry_bytes_q == 3'd3 || entry_bytes_q == 3'd4) &&
          idx >= 32'(first_q) && idx < 32'(first_q) + 32'(count_q)) begin
        word = palette_shadow[raw[7:0]];
        r.channel_blue  = word[7:0];
        r.channel_green = word[15:8];
        r.channel_red   = word[23:16];
        r.channel_alpha = (entry_bytes_q == 3'd4) ? word[31:24] : ALPHA_OPAQUE;
        r.decode_ok     = 1'b1;
      end
    end else begin
      case (src_bytes_q)
        3'd3, 3'd4: begin
          r.channel_blue  = raw[7:0];
          r.channel_green = raw[15:8];
          r.channel_red   = raw[23:16];
          r.channel_alpha = (src_bytes_q == 3'd4) ? raw[31:24] : ALPHA_OPAQUE;
          r.decode_ok     = 1'b1;
        end
        3'd2: begin
          r.channel_blue  = expand5(raw[4:0]);
          r.channel_green = expand5(raw[9:5]);
          r.channel_red   = expand5(raw[14:10]);
          r.channel_alpha = raw[15] ? ALPHA_OPAQUE : ALPHA_CLEAR;
          r.decode_ok     = 1'b1;
        end
        3'd1: begin
          r.channel_blue  = raw[7:0];
          r.channel_green = raw[7:0];
          r.channel_red   = raw[7:0];
          r.channel_alpha = ALPHA_OPAQUE;
          r.decode_ok     = 1'b1;
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        = 1'b0;
      src_bytes_q   = 3'd4;
      entry_bytes_q = 3'd4;
      first_q       = 9'd0;
      count_q       = 9'd256;
      faults        = 0;
      expected_pixels.delete();
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
    end else begin
      if (reg_i.valid && reg_i.ready) begin
        case (reg_i.data.index)
          REG_PALETTE_MODE:        mode_q        = reg_i.data.value[0];
          REG_SOURCE_BYTES:        src_bytes_q   = reg_i.data.value[2:0];
          REG_PALETTE_ENTRY_BYTES: entry_bytes_q = reg_i.data.value[2:0];
          REG_PALETTE_FIRST:       first_q       = reg_i.data.value[8:0];
          REG_PALETTE_COUNT:       count_q       = reg_i.data.value[8:0];
          default: ;
        endcase
      end
      if (pix_i.valid && pix_i.ready) begin
        if (pix_i.data.operation == OP_PALETTE_WRITE)
          palette_shadow[pix_i.data.entry_index] = pix_i.data.entry_value;
        else
          expected_pixels.push_back(unpack_pixel(pix_i.data.raw_pixel));
      end
      if (res_i.valid && res_i.ready) begin
        if (expected_pixels.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("unexpected result transfer at %0t: b=%02h g=%02h r=%02h a=%02h ok=%0b",
                     $time, res_i.data.channel_blue, res_i.data.channel_green,
                     res_i.data.channel_red, res_i.data.channel_alpha, res_i.data.decode_ok);
        end else begin
          want = expected_pixels.pop_front();
          if (res_i.data.channel_blue  !== want.channel_blue  ||
              res_i.data.channel_green !== want.channel_green ||
              res_i.data.channel_red   !== want.channel_red   ||
              res_i.data.channel_alpha !== want.channel_alpha ||
              res_i.data.decode_ok     !== want.decode_ok) begin
            faults++;
            if (faults <= 10) begin
              $write("pixel mismatch at %0t: expected b=%02h g=%02h r=%02h a=%02h ok=%0b,",
                     $time, want.channel_blue, want.channel_green, want.channel_red,
                     want.channel_alpha, want.decode_ok);
              $display(" got b=%02h g=%02h r=%02h a=%02h ok=%0b",
                       res_i.data.channel_blue, res_i.data.channel_green,
                       res_i.data.channel_red, res_i.data.channel_alpha, res_i.data.decode_ok);
            end
          end
        end
      end
      mismatch_count_o <= faults;
      pending_count_o  <= expected_pixels.size();
    end
  end

endmodule

FILE: dv/testbench.sv
// top of the targa pixel unpacker testbench: clock, reset, stimulus and verdict
module testbench;
  import tgaunp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned SETTLE_WAIT  = 6;
  localparam int unsigned RANDOM_ITEMS = 500;

  logic        clk;
  logic        rst_n;
  int unsigned mismatches;
  int unsigned pending;
  bit          calm;
  bit          entry_loaded [256];
  int unsigned fmt_palette;
  int unsigned fmt_src_bytes;
  int unsigned fmt_entry_bytes;
  int unsigned fmt_first;
  int unsigned fmt_count;

  tgaunp_in_if  pix_ch ();
  tgaunp_out_if res_ch ();
  tgaunp_cfg_if reg_ch ();

  targa_pixel_unpacker_core u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (pix_ch),
    .out_o  (res_ch),
    .cfg_i  (reg_ch)
  );

  tgaunp_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .pix_i            (pix_ch),
    .res_i            (res_ch),
    .reg_i            (reg_ch),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // result side stalls in bursts
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 8) - 1;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic push_item(input in_item_t item);
    if (!calm && $urandom_range(0, 4) == 0) begin
      pix_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.data  <= item;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    if (item.operation == OP_PALETTE_WRITE) entry_loaded[item.entry_index] = 1'b1;
  endtask

  task automatic load_entry(input logic [7:0] idx, input logic [31:0] value);
    in_item_t item;
    item.operation   = OP_PALETTE_WRITE;
    item.raw_pixel   = $urandom();
    item.entry_index = idx;
    item.entry_value = value;
    push_item(item);
  endtask

  // a lookup that palette mode would serve, of a slot never loaded, gets the slot loaded first
  task automatic send_pixel(input logic [31:0] raw);
    in_item_t    item;
    int unsigned idx;
    idx = 32'(raw[7:0]);
    if (fmt_palette == 1 && fmt_src_bytes == 1 && (fmt_entry_bytes == 3 || fmt_entry_bytes == 4) &&
        idx >= fmt_first && idx < fmt_first + fmt_count && !entry_loaded[raw[7:0]])
      load_entry(raw[7:0], $urandom());
    item.operation   = OP_DECODE;
    item.raw_pixel   = raw;
    item.entry_index = 8'($urandom());
    item.entry_value = $urandom();
    push_item(item);
  endtask

  task automatic settle();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e r, input int unsigned v);
    cfg_item_t w;
    w.index = r;
    w.value = v[CFG_DATA_W-1:0];
    reg_ch.valid <= 1'b1;
    reg_ch.data  <= w;
    @(posedge clk);
    while (!reg_ch.ready) @(posedge clk);
  endtask

  task automatic set_format(input int unsigned mode, input int unsigned sb,
                            input int unsigned eb, input int unsigned first,
                            input int unsigned count);
    settle();
    write_reg(REG_PALETTE_MODE, mode);
    write_reg(REG_SOURCE_BYTES, sb);
    write_reg(REG_PALETTE_ENTRY_BYTES, eb);
    write_reg(REG_PALETTE_FIRST, first);
    write_reg(REG_PALETTE_COUNT, count);
    reg_ch.valid <= 1'b0;
    fmt_palette     = mode;
    fmt_src_bytes   = sb;
    fmt_entry_bytes = eb;
    fmt_first       = first;
    fmt_count       = count;
  endtask

  task automatic random_format();
    int unsigned mode;
    int unsigned sb;
    int unsigned eb;
    int unsigned first;
    int unsigned count;
    mode = $urandom_range(0, 1);
    sb   = $urandom_range(0, 9);
    if (mode == 1) sb = (sb == 0) ? $urandom_range(0, 7) : 1;
    else sb = (sb < 8) ? 1 + sb % 4 : ((sb == 8) ? 0 : $urandom_range(5, 7));
    eb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 4);
    case ($urandom_range(0, 4))
      0: begin
        first = 0;
        count = 256;
      end
      1: begin
        first = $urandom_range(0, 255);
        count = $urandom_range(1, 16);
      end
      2: begin
        first = $urandom_range(0, 256);
        count = $urandom_range(0, 256);
      end
      3: begin
        first = 256;
        count = $urandom_range(0, 256);
      end
      default: begin
        first = $urandom_range(0, 255);
        count = 256 - first;
      end
    endcase
    set_format(mode, sb, eb, first, count);
  endtask

  task automatic random_item();
    int unsigned lo;
    int unsigned hi;
    logic [31:0] raw;
    lo = fmt_first;
    hi = fmt_first + fmt_count;
    if (hi > 256) hi = 256;
    if ($urandom_range(0, 9) < ((fmt_palette == 1) ? 3 : 1)) begin
      if (lo < hi && $urandom_range(0, 1) == 1)
        load_entry(8'($urandom_range(lo, hi - 1)), $urandom());
      else
        load_entry(8'($urandom()), $urandom());
    end else begin
      raw = $urandom();
      case ($urandom_range(0, 11))
        0: raw = 32'h0000_0000;
        1: raw = 32'hffff_ffff;
        2: raw = 32'h0000_8000;
        3: raw = 32'h0000_7fff;
        default: ;
      endcase
      if (fmt_palette == 1 && lo < hi && $urandom_range(0, 3) != 0)
        raw[7:0] = 8'($urandom_range(lo, hi - 1));
      send_pixel(raw);
    end
  endtask

  initial begin
    int unsigned random_sent;
    int unsigned phase;
    random_sent = 0;
    phase       = 0;
    calm        = 1'b0;
    rst_n        <= 1'b0;
    pix_ch.valid <= 1'b0;
    pix_ch.data  <= '0;
    reg_ch.valid <= 1'b0;
    reg_ch.data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // direct formats
    set_format(0, 4, 4, 0, 256);
    send_pixel(32'h0000_0000);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h80ff_01a5);
    load_entry(8'd0, 32'hffff_ffff);
    load_entry(8'd255, 32'h0000_0000);
    load_entry(8'd5, 32'h8040_2010);
    set_format(0, 3, 4, 0, 256);
    send_pixel(32'hffff_ffff);
    set_format(0, 2, 4, 0, 256);
    send_pixel(32'h0000_7fff);
    send_pixel(32'hffff_8000);
    send_pixel(32'h0000_8421);
    set_format(0, 1, 4, 0, 256);
    send_pixel(32'hffff_ff80);
    set_format(0, 0, 4, 0, 256);
    send_pixel(32'h0000_0001);
    set_format(0, 7, 4, 0, 256);
    send_pixel(32'hffff_ffff);

    // palette lookups, size errors and window edges
    set_format(1, 1, 4, 0, 256);
    send_pixel(32'h0000_0000);
    send_pixel(32'h0000_00ff);
    set_format(1, 1, 3, 0, 256);
    send_pixel(32'hffff_ffff);
    set_format(1, 1, 0, 0, 256);
    send_pixel(32'h0000_0000);
    set_format(1, 2, 4, 0, 256);
    send_pixel(32'h0000_0000);
    set_format(1, 1, 4, 5, 1);
    send_pixel(32'h0000_0004);
    send_pixel(32'h0000_0005);
    send_pixel(32'h0000_0006);
    set_format(1, 1, 4, 256, 0);
    send_pixel(32'h0000_00ff);

    while (random_sent < RANDOM_ITEMS) begin
      calm = (random_sent + 80 >= RANDOM_ITEMS) || (phase % 4 == 3);
      random_format();
      repeat ($urandom_range(20, 50)) begin
        random_item();
        random_sent++;
      end
      phase++;
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
